// File: rtl/dbpd_pkg.sv
// Shared types and reset constants for the debounced button PWM dimmer.
// No dependencies; imported by every module of the block.
package dbpd_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned CfgIdxW = 8;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegDebounceLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPwmTop        = 8'd1;
  localparam logic [CfgIdxW-1:0] RegDutyStep      = 8'd2;
  localparam logic [CfgIdxW-1:0] RegDutyMax       = 8'd3;

  // Reset values
  localparam logic [DataW-1:0] RstDebounceLimit = 16'd1999;
  localparam logic [DataW-1:0] RstPwmTop        = 16'd999;
  localparam logic [DataW-1:0] RstDutyStep      = 16'd100;
  localparam logic [DataW-1:0] RstDutyMax       = 16'd900;
  localparam logic [DataW-1:0] RstDuty          = 16'd499;

  // Confirmed button events from the debouncer to the PWM unit
  typedef struct packed {
    logic press;
    logic release_ev;
  } dbpd_event_t;

  // PWM unit status toward the output register
  typedef struct packed {
    logic             running;
    logic             led;
    logic [DataW-1:0] duty;
  } dbpd_pwm_stat_t;

endpackage

// File: rtl/dbpd_debounce.sv
// Button debouncer: edge detect, debounce counter and press/release judging.
// Depends on dbpd_pkg.
module dbpd_debounce
  import dbpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             level,
  input  logic [DataW-1:0] limit,
  output dbpd_event_t      ev,
  output logic             press_led_nxt
);

  logic             last_level_r, last_level_nxt;
  logic [DataW-1:0] count_r, count_nxt;
  logic             active_r, active_nxt;
  logic             await_r, await_nxt;
  logic             press_led_r;
  logic             at_limit;
  logic             edge_seen;

  always_comb begin
    at_limit      = active_r && (count_r == limit);
    ev.press      = at_limit && !await_r && !level;
    ev.release_ev = at_limit && await_r && level;

    active_nxt = active_r && !at_limit;
    count_nxt  = (active_r && !at_limit) ? count_r + 16'd1 : count_r;

    await_nxt     = await_r;
    press_led_nxt = press_led_r;
    if (ev.press) begin
      await_nxt     = 1'b1;
      press_led_nxt = 1'b1;
    end else if (ev.release_ev) begin
      await_nxt     = 1'b0;
      press_led_nxt = 1'b0;
    end

    // edge direction follows the wait state as updated this tick
    edge_seen = await_nxt ? (!last_level_r && level) : (last_level_r && !level);
    if (edge_seen) begin
      count_nxt  = '0;
      active_nxt = 1'b1;
    end
    last_level_nxt = level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b1;
      count_r      <= '0;
      active_r     <= 1'b0;
      await_r      <= 1'b0;
      press_led_r  <= 1'b0;
    end else if (step) begin
      last_level_r <= last_level_nxt;
      count_r      <= count_nxt;
      active_r     <= active_nxt;
      await_r      <= await_nxt;
      press_led_r  <= press_led_nxt;
    end
  end

endmodule

// File: rtl/dbpd_pwm.sv
// PWM period counter, LED compare and duty update on confirmed presses.
// Depends on dbpd_pkg.
module dbpd_pwm
  import dbpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  dbpd_event_t      ev,
  input  logic [DataW-1:0] pwm_top,
  input  logic [DataW-1:0] duty_step,
  input  logic [DataW-1:0] duty_max,
  output dbpd_pwm_stat_t   stat_nxt,
  output dbpd_pwm_stat_t   stat
);

  logic [DataW-1:0] count_r, count_nxt;
  logic [DataW-1:0] duty_r;
  logic             running_r;
  logic             led_r;
  logic [DataW:0]   duty_sum;

  always_comb begin
    stat_nxt.running = running_r;
    stat_nxt.led     = led_r;
    stat_nxt.duty    = duty_r;
    count_nxt        = count_r;

    // advance the period with the old duty
    if (running_r) begin
      if (count_r == duty_r) begin
        stat_nxt.led = 1'b0;
      end else if (count_r == pwm_top) begin
        stat_nxt.led = 1'b1;
      end
      count_nxt = (count_r >= pwm_top) ? '0 : count_r + 16'd1;
    end

    // step the duty, saturating, or wrap to zero and stop
    duty_sum = {1'b0, duty_r} + {1'b0, duty_step};
    if (ev.press) begin
      if (duty_r <= duty_max) begin
        stat_nxt.duty    = duty_sum[DataW] ? '1 : duty_sum[DataW-1:0];
        stat_nxt.running = 1'b1;
      end else begin
        stat_nxt.duty    = '0;
        stat_nxt.running = 1'b0;
        stat_nxt.led     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      duty_r    <= RstDuty;
      running_r <= 1'b1;
      led_r     <= 1'b0;
    end else if (step) begin
      count_r   <= count_nxt;
      duty_r    <= stat_nxt.duty;
      running_r <= stat_nxt.running;
      led_r     <= stat_nxt.led;
    end
  end

  assign stat.running = running_r;
  assign stat.led     = led_r;
  assign stat.duty    = duty_r;

endmodule

// File: rtl/debounced_button_pwm_dimmer_top.sv
// Top level of the debounced button PWM dimmer: stream ports, config registers,
// input and result registers. Depends on dbpd_pkg, dbpd_debounce and dbpd_pwm.
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+------------------------------------
//   in_     | in  | in_tvalid/in_tready  | button tick, raw pin level
//   out_    | out | out_tvalid/out_tready| press LED, PWM LED, duty
//   cfg_    | in  | cfg_valid/cfg_ready  | register index and 16-bit value
//
// One word per cycle sustained while out_tready stays high: a tick lands in
// the input register, then the debouncer and PWM unit update their state and
// load the result register, both in one pass. Reset is synchronous, active
// low, and restores all state and registers but the level and result payloads.
// A stalled result register holds the input register; in_tready drops only when
// both are full and the result is not taken. Configuration is always accepted.
module debounced_button_pwm_dimmer_top
  import dbpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [0] button_level, [7:1] zero
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,  // [0] press_led, [1] pwm_led,
                                         // [17:2] duty_now, [23:18] zero
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data
);

  logic [DataW-1:0] debounce_limit_r;
  logic [DataW-1:0] pwm_top_r;
  logic [DataW-1:0] duty_step_r;
  logic [DataW-1:0] duty_max_r;

  logic             in_valid_r;
  logic             level_r;
  logic             out_valid_r;
  logic [DataW+1:0] out_data_r;

  logic             advance;
  logic             step;
  dbpd_event_t      ev;
  logic             press_led_nxt;
  dbpd_pwm_stat_t   pwm_stat_nxt;
  dbpd_pwm_stat_t   pwm_stat;

  // Configuration registers; writes beyond the list drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_limit_r <= RstDebounceLimit;
      pwm_top_r        <= RstPwmTop;
      duty_step_r      <= RstDutyStep;
      duty_max_r       <= RstDutyMax;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegDebounceLimit: debounce_limit_r <= cfg_data;
        RegPwmTop:        pwm_top_r        <= cfg_data;
        RegDutyStep:      duty_step_r      <= cfg_data;
        RegDutyMax:       duty_max_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register can take a word when empty or draining this cycle
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Capture the level; payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      level_r <= in_tdata[0];
    end
  end

  dbpd_debounce u_debounce (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .level         (level_r),
    .limit         (debounce_limit_r),
    .ev            (ev),
    .press_led_nxt (press_led_nxt)
  );

  dbpd_pwm u_pwm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ev        (ev),
    .pwm_top   (pwm_top_r),
    .duty_step (duty_step_r),
    .duty_max  (duty_max_r),
    .stat_nxt  (pwm_stat_nxt),
    .stat      (pwm_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  // Load the post-tick values of this word
  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {pwm_stat_nxt.duty, pwm_stat_nxt.led, press_led_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

  // A single judgment is either a press or a release
  assert property (@(posedge clk) disable iff (!rst_n)
    !(ev.press && ev.release_ev))
    else $error("press and release confirmed in the same tick");

  // Stopped PWM keeps its LED dark
  assert property (@(posedge clk) disable iff (!rst_n)
    !pwm_stat.running |-> !pwm_stat.led)
    else $error("PWM LED lit while stopped");

  // Only a wrap stops the PWM, and it leaves the duty at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    !pwm_stat.running |-> (pwm_stat.duty == '0))
    else $error("PWM stopped with nonzero duty");

  // An empty result register never stalls the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

// File: tb/sv/debounced_button_pwm_dimmer_top_test.sv
// Self-checking testbench for debounced_button_pwm_dimmer_top: streams button ticks,
// predicts each result word in-line, and compares it with the block's output stream.
// Depends on dbpd_pkg and the RTL of the dimmer.
module debounced_button_pwm_dimmer_top_test
  import dbpd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no word moving on any channel before the run is declared hung
  localparam int unsigned StuckLimit = 2000;
  // Cap on printed mismatch lines; every mismatch still counts
  localparam int unsigned PrintCap   = 100;
  // Cycles the receiver holds off when asked to squeeze the block
  localparam int unsigned HoldOffLen = 64;

  // One result word: press LED, PWM LED, duty compare value
  typedef struct packed {
    logic             press;
    logic             pwm;
    logic [DataW-1:0] duty;
  } lamp_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = 8'd0;   // [0] button_level, [7:1] zero
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [23:0]        out_tdata;           // [0] press_led, [1] pwm_led, [17:2] duty_now
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index  = RegDebounceLimit;
  logic [DataW-1:0]   cfg_data   = '0;

  // Button levels waiting to be sent, and result words still owed by the block
  bit          level_q[$];
  lamp_t       lamp_due[$];
  int unsigned pushed;

  // Pacing knobs shared between the scenario and the two stream processes
  int unsigned in_gap_max  = 0;
  int unsigned out_gap_max = 0;
  int unsigned in_wait     = 0;
  int unsigned out_wait    = 0;
  int unsigned hold_left   = 0;
  bit          in_taken    = 1'b0;
  bit          ready_hold_req = 1'b0;

  int unsigned mismatches   = 0;
  int unsigned stuck_cycles = 0;

  // Predicted register copies
  logic [DataW-1:0] lim_c, top_c, step_c, dmax_c;
  // Predicted block state
  logic             lvl_prev, db_run, wait_rel, pwm_on, press_q, pwm_q;
  logic [DataW-1:0] db_cnt, duty_q, pwm_cnt;

  debounced_button_pwm_dimmer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Advance the predicted dimmer by one tick and queue the word it must produce.
  // Order matters: PWM first on the old duty, then the debounce counter, then
  // edge detection against the release flag as this tick left it.
  function automatic void dimmer_tick(input logic level);
    logic             hit;
    logic [DataW:0]   sum;
    lamp_t            word;
    if (pwm_on) begin
      // clear on duty wins over set on top
      if (pwm_cnt == duty_q) begin
        pwm_q = 1'b0;
      end else if (pwm_cnt == top_c) begin
        pwm_q = 1'b1;
      end
      // top written below the count sends it straight back to zero
      if (pwm_cnt >= top_c) begin
        pwm_cnt = '0;
      end else begin
        pwm_cnt = pwm_cnt + 1'b1;
      end
    end
    if (db_run) begin
      if (db_cnt == lim_c) begin
        db_run = 1'b0;
        if (!wait_rel && !level) begin
          press_q  = 1'b1;
          wait_rel = 1'b1;
          if (duty_q <= dmax_c) begin
            // step up, saturating at full scale; a stopped PWM resumes here
            sum    = {1'b0, duty_q} + {1'b0, step_c};
            duty_q = sum[DataW] ? {DataW{1'b1}} : sum[DataW-1:0];
            pwm_on = 1'b1;
          end else begin
            // past the maximum: duty back to zero, PWM halted with LED dark
            duty_q = '0;
            pwm_on = 1'b0;
            pwm_q  = 1'b0;
          end
        end else if (wait_rel && level) begin
          press_q  = 1'b0;
          wait_rel = 1'b0;
        end
      end else begin
        // limit below the count wraps through full scale
        db_cnt = db_cnt + 1'b1;
      end
    end
    hit = wait_rel ? (!lvl_prev && level) : (lvl_prev && !level);
    if (hit) begin
      db_cnt = '0;
      db_run = 1'b1;
    end
    lvl_prev   = level;
    word.press = press_q;
    word.pwm   = pwm_q;
    word.duty  = duty_q;
    lamp_due.push_back(word);
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatches < PrintCap) begin
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Capture side of the driver: take accepted words into the predictor at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegDebounceLimit: lim_c  = cfg_data;
          RegPwmTop:        top_c  = cfg_data;
          RegDutyStep:      step_c = cfg_data;
          RegDutyMax:       dmax_c = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        dimmer_tick(in_tdata[0]);
        level_q.delete(0);
        in_taken = 1'b1;
        in_wait  = $urandom_range(0, in_gap_max);
      end
    end
  end

  // Drive side: hold an offered word until taken, idle for the drawn gap, then
  // offer the next pending level.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (in_wait > 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (level_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, level_q[0]};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // Receiver pacing: a long hold-off on request, otherwise the per-word stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (ready_hold_req) begin
        hold_left      = HoldOffLen;
        ready_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare every accepted result word with the oldest one owed.
  always @(posedge clk) begin : check_results
    lamp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      out_wait = $urandom_range(0, out_gap_max);
      if (lamp_due.size() == 0) begin
        flag_mismatch("result word with none owed, duty", out_tdata[17:2], 0);
      end else begin
        want = lamp_due.pop_front();
        if (out_tdata[0] !== want.press) begin
          flag_mismatch("press_led", out_tdata[0], want.press);
        end
        if (out_tdata[1] !== want.pwm) begin
          flag_mismatch("pwm_led", out_tdata[1], want.pwm);
        end
        if (out_tdata[17:2] !== want.duty) begin
          flag_mismatch("duty_now", out_tdata[17:2], want.duty);
        end
      end
    end
  end

  // Watchdog: any word moving on any channel resets the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [DataW-1:0] lim, input logic [DataW-1:0] top,
                          input logic [DataW-1:0] step, input logic [DataW-1:0] dmax);
    write_reg(RegDebounceLimit, lim);
    write_reg(RegPwmTop, top);
    write_reg(RegDutyStep, step);
    write_reg(RegDutyMax, dmax);
  endtask

  // Block until every level is sent and every owed word has come back, then
  // let the pipeline settle.
  task automatic wait_drained();
    while (level_q.size() != 0 || lamp_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic push_run(input bit lv, input int unsigned n);
    repeat (n) begin
      level_q.push_back(lv);
      pushed++;
    end
  endtask

  task automatic push_noise(input int unsigned n);
    repeat (n) begin
      push_run(1'($urandom_range(0, 1)), 1);
    end
  endtask

  // Mostly clean press/release cycles with bounce around the edges; the rest
  // is raw chatter and short presses, some let go before the debounce window closes.
  task automatic fill_random(input logic [DataW-1:0] lim, input int unsigned n);
    int unsigned pick;
    int unsigned h;
    while (pushed < n) begin
      pick = $urandom_range(0, 99);
      h    = (lim > 64) ? $urandom_range(1, 8) : int'(lim) + 2 + $urandom_range(0, 4);
      if (pick < 70) begin
        push_noise($urandom_range(0, 4));
        push_run(1'b0, h);
        push_noise($urandom_range(0, 3));
        push_run(1'b1, h);
      end else if (pick < 85) begin
        push_noise($urandom_range(1, 8));
      end else begin
        push_run(1'b0, $urandom_range(1, h));
        push_run(1'b1, 2);
      end
    end
  endtask

  task automatic run_phase(input logic [DataW-1:0] lim, input logic [DataW-1:0] top,
                           input logic [DataW-1:0] step, input logic [DataW-1:0] dmax,
                           input int unsigned n, input int unsigned gap, input bit squeeze);
    set_regs(lim, top, step, dmax);
    in_gap_max  = gap;
    out_gap_max = gap;
    pushed      = 0;
    fill_random(lim, n);
    // with the sender still offering, a long receiver hold-off backs up the block
    if (squeeze) begin
      ready_hold_req = 1'b1;
    end
    wait_drained();
  endtask

  initial begin
    // predicted state after reset
    lim_c    = RstDebounceLimit;
    top_c    = RstPwmTop;
    step_c   = RstDutyStep;
    dmax_c   = RstDutyMax;
    lvl_prev = 1'b1;
    db_cnt   = '0;
    db_run   = 1'b0;
    wait_rel = 1'b0;
    duty_q   = RstDuty;
    pwm_cnt  = '0;
    pwm_on   = 1'b1;
    press_q  = 1'b0;
    pwm_q    = 1'b0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a few ticks on the reset settings
    in_gap_max  = 2;
    out_gap_max = 2;
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 2);
    wait_drained();

    // Directed: zero debounce limit (judged the tick after the edge), zero PWM
    // top, full-scale step. Press 1 saturates the duty, press 2 is past the
    // maximum and halts the PWM at zero duty, press 3 steps up and restarts it.
    set_regs(16'd0, 16'd0, 16'hFFFF, 16'd900);
    repeat (3) begin
      push_run(1'b0, 2);
      push_run(1'b1, 2);
    end
    // an edge whose level is gone by the sampling tick changes nothing
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 2);
    wait_drained();

    // Random phases across register settings, extremes included
    run_phase(16'd3,     16'd20,    16'd5,     16'd60,    180, 16, 1'b0);
    run_phase(16'd1,     16'hFFFF,  16'd1,     16'hFFFF,  100, 16, 1'b0);
    // top drops below the running count here
    run_phase(16'd7,     16'd1,     16'd1000,  16'd0,     150, 8,  1'b0);
    run_phase(16'd2,     16'd40,    16'hFFFF,  16'd30000, 180, 0,  1'b1);
    run_phase(16'd0,     16'd0,     16'd0,     16'd900,   100, 16, 1'b0);
    run_phase(16'd12,    16'd100,   16'd37,    16'd500,   180, 16, 1'b0);
    run_phase(16'hFFFF,  16'd9,     16'd3,     16'd50,    50,  4,  1'b0);
    run_phase(16'd4,     16'd3,     16'd250,   16'd700,   140, 16, 1'b0);

    // Limit written below a running count: the count runs on past the new
    // limit with no judgment until a fresh falling edge restarts it.
    set_regs(16'd30, 16'd5, 16'd3, 16'd50);
    in_gap_max  = 0;
    out_gap_max = 0;
    push_run(1'b1, 3);
    push_run(1'b0, 20);
    wait_drained();
    write_reg(RegDebounceLimit, 16'd10);
    push_run(1'b0, 20);
    push_run(1'b1, 2);
    push_run(1'b0, 16);
    push_run(1'b1, 16);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dbpd_pkg.sv
rtl/dbpd_debounce.sv
rtl/dbpd_pwm.sv
rtl/debounced_button_pwm_dimmer_top.sv
tb/sv/debounced_button_pwm_dimmer_top_test.sv
